FILE: rtl/ctt_pkg.sv
// Shared types and constants for the config text tokenizer.
// Used by the front lexer, the result queue and the top level.
package ctt_pkg;

	localparam int PosBits = 24;
	localparam int NumTextMax = 127;
	localparam int CountBits = 7;

	typedef enum logic [4:0] {
		MD_IDLE, MD_SLASH, MD_COMMENT, MD_MINUS, MD_IDENT, MD_TAG0, MD_TAG,
		MD_STR, MD_ESC, MD_ZERO, MD_INT, MD_INT_US, MD_FRAC0, MD_FRAC,
		MD_FRAC_US, MD_EXP0, MD_EXP_SIGN, MD_EXP, MD_EXP_US, MD_HEX0, MD_HEX,
		MD_HEX_US, MD_DONE
	} mode_t;

	localparam logic [1:0] RK_TOKEN = 2'd0;
	localparam logic [1:0] RK_BYTE = 2'd1;
	localparam logic [1:0] RK_ERROR = 2'd2;

	localparam logic [3:0] TK_END = 4'd0;
	localparam logic [3:0] TK_IDENT = 4'd1;
	localparam logic [3:0] TK_TAG = 4'd2;
	localparam logic [3:0] TK_NUM = 4'd3;
	localparam logic [3:0] TK_STR = 4'd4;

	localparam logic [3:0] EC_UNKNOWN = 4'd0;
	localparam logic [3:0] EC_UNTERM = 4'd1;
	localparam logic [3:0] EC_STR_CHAR = 4'd2;
	localparam logic [3:0] EC_ESCAPE = 4'd3;
	localparam logic [3:0] EC_SEPARATOR = 4'd4;
	localparam logic [3:0] EC_NO_HEX = 4'd5;
	localparam logic [3:0] EC_NO_DIGIT = 4'd6;
	localparam logic [3:0] EC_TOO_LONG = 4'd7;
	localparam logic [3:0] EC_SRC_LONG = 4'd8;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [3:0] token_kind;
		logic [PosBits-1:0] start_offset;
		logic [PosBits-1:0] lexeme_length;
		logic [7:0] content_byte;
		logic number_is_hex;
		logic number_negative;
		logic [63:0] hex_magnitude;
		logic hex_overflow;
		logic [3:0] error_code;
		logic last_of_item;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic ident_first(input logic [7:0] c);
		return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		case (c)
			"{": return 4'd5;
			"}": return 4'd6;
			"[": return 4'd7;
			"]": return 4'd8;
			"(": return 4'd9;
			")": return 4'd10;
			":": return 4'd11;
			",": return 4'd12;
			default: return 4'd0;
		endcase
	endfunction

	// Hex digit value in the low nibble, valid flag on top.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (is_digit(c)) return {1'b1, 4'(c - 8'h30)};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - 8'h57)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - 8'h37)};
		return 5'd0;
	endfunction

	// Escape value in the low byte, valid flag on top.
	function automatic logic [8:0] unescape(input logic [7:0] c);
		case (c)
			"r": return {1'b1, 8'h0d};
			"n": return {1'b1, 8'h0a};
			"t": return {1'b1, 8'h09};
			"0": return {1'b1, 8'h00};
			"'": return {1'b1, 8'h27};
			"\\": return {1'b1, 8'h5c};
			"\"": return {1'b1, 8'h22};
			default: return 9'd0;
		endcase
	endfunction

endpackage

FILE: rtl/ctt_front.sv
// Front part of the tokenizer: lexer FSM, classifies one byte a cycle while take is high.
// Depends on ctt_pkg; produces up to two results per input beat.
module ctt_front
	import ctt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [7:0] source_byte,
	input  logic end_of_source,
	output logic [1:0] res_count,
	output result_t res0,
	output result_t res1
);

	mode_t mode_q, mode_d;
	logic [PosBits-1:0] pos_q, pos_d, start_q, start_d;
	logic [CountBits-1:0] cnt_q, cnt_d;
	logic [63:0] acc_q, acc_d;
	logic ovf_q, ovf_d, sign_q, sign_d, halt_q, halt_d;

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MD_IDLE;
			pos_q <= '0;
			start_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			sign_q <= 1'b0;
			halt_q <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			pos_q <= pos_d;
			start_q <= start_d;
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			ovf_q <= ovf_d;
			sign_q <= sign_d;
			halt_q <= halt_d;
		end
	end

	// Next state and results for the current byte.
	always_comb begin
		logic [7:0] c;
		logic fin_end, err, fin, idle_go, endt, cnt_full, in_hex;
		logic [3:0] ecode, fkind, pk;
		logic [4:0] hv;
		logic [8:0] ev;
		result_t r, z;
		logic [1:0] n;
		result_t q0, q1;

		c = source_byte;
		fin_end = end_of_source || (c == 8'd0);
		mode_d = mode_q;
		pos_d = pos_q;
		start_d = start_q;
		cnt_d = cnt_q;
		acc_d = acc_q;
		ovf_d = ovf_q;
		sign_d = sign_q;
		halt_d = halt_q;
		err = 1'b0;
		ecode = EC_UNKNOWN;
		fin = 1'b0;
		fkind = TK_IDENT;
		idle_go = 1'b0;
		endt = 1'b0;
		cnt_full = (cnt_q >= CountBits'(NumTextMax));
		hv = hex_val(c);
		ev = unescape(c);
		pk = punct_kind(c);
		in_hex = (mode_q == MD_HEX);
		z = '0;
		r = '0;
		n = 2'd0;
		q0 = '0;
		q1 = '0;

		if (halt_q) begin
			n = 2'd0;
		end else if (mode_q == MD_DONE) begin
			endt = 1'b1;
		end else if (!fin_end && pos_q == {PosBits{1'b1}}) begin
			err = 1'b1;
			ecode = EC_SRC_LONG;
		end else begin
			case (mode_q)
				MD_SLASH: begin
					if (!fin_end && c == "/") mode_d = MD_COMMENT;
					else err = 1'b1;
				end
				MD_COMMENT: begin
					if (fin_end) idle_go = 1'b1;
					else if (c == 8'h0a) mode_d = MD_IDLE;
				end
				MD_MINUS: begin
					if (!fin_end && is_digit(c)) begin
						if (cnt_full) begin
							err = 1'b1;
							ecode = EC_TOO_LONG;
						end else begin
							cnt_d = cnt_q + 1'b1;
							mode_d = (c == "0") ? MD_ZERO : MD_INT;
						end
					end else err = 1'b1;
				end
				MD_IDENT, MD_TAG: begin
					if (fin_end || !(ident_first(c) || is_digit(c))) begin
						fin = 1'b1;
						fkind = (mode_q == MD_IDENT) ? TK_IDENT : TK_TAG;
					end
				end
				MD_TAG0: begin
					if (!fin_end && ident_first(c)) mode_d = MD_TAG;
					else err = 1'b1;
				end
				MD_STR: begin
					if (fin_end) begin
						err = 1'b1;
						ecode = EC_UNTERM;
					end else if (c == "\"") begin
						r.result_kind = RK_TOKEN;
						r.token_kind = TK_STR;
						r.start_offset = start_q;
						r.lexeme_length = pos_q + 1'b1 - start_q;
						q0 = r;
						n = 2'd1;
						mode_d = MD_IDLE;
					end else if (c == 8'h0a || c == 8'h0d || c == 8'h09) begin
						err = 1'b1;
						ecode = EC_STR_CHAR;
					end else if (c == "\\") begin
						mode_d = MD_ESC;
					end else begin
						r.result_kind = RK_BYTE;
						r.token_kind = TK_STR;
						r.start_offset = start_q;
						r.content_byte = c;
						q0 = r;
						n = 2'd1;
					end
				end
				MD_ESC: begin
					if (fin_end || !ev[8]) begin
						err = 1'b1;
						ecode = EC_ESCAPE;
					end else begin
						r.result_kind = RK_BYTE;
						r.token_kind = TK_STR;
						r.start_offset = start_q;
						r.content_byte = ev[7:0];
						q0 = r;
						n = 2'd1;
						mode_d = MD_STR;
					end
				end
				MD_ZERO, MD_INT, MD_FRAC, MD_EXP: begin
					if (mode_q == MD_ZERO && !fin_end && (c == "x" || c == "X")) begin
						mode_d = MD_HEX0;
					end else if (fin_end) begin
						fin = 1'b1;
						fkind = TK_NUM;
					end else if (is_digit(c) || (c == "." &&
						(mode_q == MD_ZERO || mode_q == MD_INT)) ||
						((c == "e" || c == "E") && mode_q != MD_EXP)) begin
						if (cnt_full) begin
							err = 1'b1;
							ecode = EC_TOO_LONG;
						end else begin
							cnt_d = cnt_q + 1'b1;
							if (c == ".") mode_d = MD_FRAC0;
							else if (c == "e" || c == "E") mode_d = MD_EXP0;
							else if (mode_q == MD_ZERO) mode_d = MD_INT;
						end
					end else if (c == "_") begin
						case (mode_q)
							MD_FRAC: mode_d = MD_FRAC_US;
							MD_EXP: mode_d = MD_EXP_US;
							default: mode_d = MD_INT_US;
						endcase
					end else begin
						fin = 1'b1;
						fkind = TK_NUM;
					end
				end
				MD_INT_US, MD_FRAC_US, MD_EXP_US: begin
					if (!fin_end && c == "_") begin
						mode_d = mode_q;
					end else if (!fin_end && is_digit(c)) begin
						if (cnt_full) begin
							err = 1'b1;
							ecode = EC_TOO_LONG;
						end else begin
							cnt_d = cnt_q + 1'b1;
							case (mode_q)
								MD_FRAC_US: mode_d = MD_FRAC;
								MD_EXP_US: mode_d = MD_EXP;
								default: mode_d = MD_INT;
							endcase
						end
					end else begin
						err = 1'b1;
						ecode = EC_SEPARATOR;
					end
				end
				MD_FRAC0, MD_EXP_SIGN, MD_EXP0: begin
					if (!fin_end && (is_digit(c) ||
						(mode_q == MD_EXP0 && (c == "+" || c == "-")))) begin
						if (cnt_full) begin
							err = 1'b1;
							ecode = EC_TOO_LONG;
						end else begin
							cnt_d = cnt_q + 1'b1;
							if (!is_digit(c)) mode_d = MD_EXP_SIGN;
							else if (mode_q == MD_FRAC0) mode_d = MD_FRAC;
							else mode_d = MD_EXP;
						end
					end else begin
						err = 1'b1;
						ecode = EC_NO_DIGIT;
					end
				end
				MD_HEX0, MD_HEX, MD_HEX_US: begin
					if (!fin_end && hv[4]) begin
						if (acc_q[63:60] != 4'd0) ovf_d = 1'b1;
						acc_d = {acc_q[59:0], hv[3:0]};
						mode_d = MD_HEX;
					end else if (mode_q != MD_HEX0 && !fin_end && c == "_") begin
						mode_d = MD_HEX_US;
					end else if (mode_q == MD_HEX) begin
						fin = 1'b1;
						fkind = TK_NUM;
					end else begin
						err = 1'b1;
						ecode = (mode_q == MD_HEX0) ? EC_NO_HEX : EC_SEPARATOR;
					end
				end
				default: idle_go = 1'b1;
			endcase

			// Token finished: emit it, then lex this byte from idle.
			if (fin) begin
				r = '0;
				r.result_kind = RK_TOKEN;
				r.token_kind = fkind;
				r.start_offset = start_q;
				r.lexeme_length = pos_q - start_q;
				if (fkind == TK_NUM) begin
					r.number_is_hex = in_hex;
					r.number_negative = sign_q;
					r.hex_magnitude = in_hex ? acc_q : 64'd0;
					r.hex_overflow = in_hex && ovf_q;
				end
				q0 = r;
				n = 2'd1;
				idle_go = 1'b1;
			end

			// Lexing from idle.
			if (idle_go) begin
				mode_d = MD_IDLE;
				start_d = pos_q;
				r = '0;
				if (fin_end) begin
					r.result_kind = RK_TOKEN;
					r.token_kind = TK_END;
					r.start_offset = pos_q;
					if (n == 2'd0) q0 = r; else q1 = r;
					n = n + 1'b1;
					mode_d = MD_DONE;
				end else if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) begin
					mode_d = MD_IDLE;
				end else if (c == "/") mode_d = MD_SLASH;
				else if (c == "\"") mode_d = MD_STR;
				else if (c == "@") mode_d = MD_TAG0;
				else if (ident_first(c)) mode_d = MD_IDENT;
				else if (is_digit(c) || c == "-") begin
					cnt_d = CountBits'(1);
					acc_d = '0;
					ovf_d = 1'b0;
					sign_d = (c == "-");
					if (c == "-") mode_d = MD_MINUS;
					else mode_d = (c == "0") ? MD_ZERO : MD_INT;
				end else if (pk != 4'd0) begin
					r.result_kind = RK_TOKEN;
					r.token_kind = pk;
					r.start_offset = pos_q;
					r.lexeme_length = PosBits'(1);
					if (n == 2'd0) q0 = r; else q1 = r;
					n = n + 1'b1;
				end else begin
					err = 1'b1;
					ecode = EC_UNKNOWN;
				end
			end
		end

		if (endt) begin
			r = '0;
			r.result_kind = RK_TOKEN;
			r.token_kind = TK_END;
			r.start_offset = pos_q;
			q0 = r;
			n = 2'd1;
		end

		// Error result halts the block; the start is that of the new token if any.
		if (err) begin
			r = z;
			r.result_kind = RK_ERROR;
			r.start_offset = idle_go ? pos_q : start_q;
			r.error_code = ecode;
			if (n == 2'd0) q0 = r; else q1 = r;
			n = n + 1'b1;
			halt_d = 1'b1;
		end

		if (!halt_q && mode_q != MD_DONE && !fin_end && !err) pos_d = pos_q + 1'b1;

		if (n == 2'd1) q0.last_of_item = 1'b1;
		if (n == 2'd2) q1.last_of_item = 1'b1;
		res_count = n;
		res0 = q0;
		res1 = q1;
	end

endmodule

FILE: rtl/ctt_queue.sv
// Back part: a four-entry result queue that takes up to two results a beat
// and delivers one a beat. Depends on ctt_pkg.
module ctt_queue
	import ctt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [1:0] push_count,
	input  result_t push0,
	input  result_t push1,
	output logic room,
	output logic out_valid,
	input  logic out_ready,
	output result_t out_data
);

	result_t mem_q [4];
	logic [1:0] rd_q, wr_q;
	logic [2:0] fill_q;
	logic pop;
	logic [1:0] n_in;

	assign pop = out_valid && out_ready;
	assign n_in = push ? push_count : 2'd0;
	assign out_valid = fill_q != 3'd0;
	assign out_data = mem_q[rd_q];
	// Room for two more regardless of what drains this cycle.
	assign room = fill_q <= 3'd2;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			fill_q <= '0;
		end else begin
			rd_q <= rd_q + 2'(pop);
			wr_q <= wr_q + n_in;
			fill_q <= fill_q + 3'(n_in) - 3'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (n_in != 2'd0) mem_q[wr_q] <= push0;
		if (n_in == 2'd2) mem_q[wr_q + 2'd1] <= push1;
	end

endmodule

FILE: rtl/config_text_tokenizer_core.sv
// Config text tokenizer: one source byte per input beat, one result per output beat.
// Lexes a JSON-like language, skipping whitespace and line comments.
// A front lexer classifies each byte and yields zero to two results; a
// four-entry queue parts it from the output channel.
// Input: source_byte and end_of_source, valid/ready. A zero byte also ends.
// Output: one result per beat, last_of_item marks the final result of a beat.
// Results are registered into the queue when their beat is taken, behind any older ones.
// Throughput: one input beat per cycle while the output keeps up; a beat
// that makes two results hands them out one per output beat, set by the single
// output port of the queue.
// Input ready is high while the queue has room for two results, so a
// stalled receiver fills the queue and then holds off input.
// Reset clears the lexer to idle at position zero and empties the queue.
// After an error no further results come until reset; after the end token
// each further beat gives another end token.
module config_text_tokenizer_core
	import ctt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] source_byte,
	input  logic end_of_source,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] result_kind,
	output logic [3:0] token_kind,
	output logic [23:0] start_offset,
	output logic [23:0] lexeme_length,
	output logic [7:0] content_byte,
	output logic number_is_hex,
	output logic number_negative,
	output logic [63:0] hex_magnitude,
	output logic hex_overflow,
	output logic [3:0] error_code,
	output logic last_of_item
);

	logic take;
	logic [1:0] cnt;
	result_t r0, r1, od;

	assign take = in_valid && in_ready;

	// Lexer front end.
	ctt_front u_front (
		.clk(clk), .arst_n(arst_n), .take(take),
		.source_byte(source_byte), .end_of_source(end_of_source),
		.res_count(cnt), .res0(r0), .res1(r1)
	);

	// Result queue.
	ctt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(take), .push_count(cnt),
		.push0(r0), .push1(r1), .room(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(od)
	);

	assign result_kind = od.result_kind;
	assign token_kind = od.token_kind;
	assign start_offset = od.start_offset;
	assign lexeme_length = od.lexeme_length;
	assign content_byte = od.content_byte;
	assign number_is_hex = od.number_is_hex;
	assign number_negative = od.number_negative;
	assign hex_magnitude = od.hex_magnitude;
	assign hex_overflow = od.hex_overflow;
	assign error_code = od.error_code;
	assign last_of_item = od.last_of_item;

endmodule

FILE: tb/tb.sv
// Self-checking bench for config_text_tokenizer_core: streams source text, predicts every
// token, content byte and error in a built-in lexer model, and checks each output beat.
// Depends on ctt_pkg and the config_text_tokenizer_core RTL.
module tb;
	import ctt_pkg::*;

	localparam logic [3:0] TK_LBRACE = 4'd5;
	localparam logic [3:0] TK_RBRACE = 4'd6;
	localparam logic [3:0] TK_LBRACKET = 4'd7;
	localparam logic [3:0] TK_RBRACKET = 4'd8;
	localparam logic [3:0] TK_LPAREN = 4'd9;
	localparam logic [3:0] TK_RPAREN = 4'd10;
	localparam logic [3:0] TK_PAIR_SEP = 4'd11;
	localparam logic [3:0] TK_ITEM_SEP = 4'd12;
	localparam int RandomBeats = 530;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] source_byte;
	logic end_of_source;
	logic out_valid;
	logic out_ready;
	logic [1:0] result_kind;
	logic [3:0] token_kind;
	logic [23:0] start_offset;
	logic [23:0] lexeme_length;
	logic [7:0] content_byte;
	logic number_is_hex;
	logic number_negative;
	logic [63:0] hex_magnitude;
	logic hex_overflow;
	logic [3:0] error_code;
	logic last_of_item;

	config_text_tokenizer_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.source_byte(source_byte), .end_of_source(end_of_source),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_kind(result_kind), .token_kind(token_kind),
		.start_offset(start_offset), .lexeme_length(lexeme_length),
		.content_byte(content_byte), .number_is_hex(number_is_hex),
		.number_negative(number_negative), .hex_magnitude(hex_magnitude),
		.hex_overflow(hex_overflow), .error_code(error_code),
		.last_of_item(last_of_item)
	);

	// Lexer model state.
	mode_t lx_mode;
	logic [23:0] lx_pos;
	logic [23:0] lx_start;
	int lx_count;
	logic [63:0] lx_hex;
	bit lx_hex_ovf;
	bit lx_neg;
	bit lx_halted;

	result_t beat_results [2];
	int beat_nres;
	result_t pending_tokens [$];

	int beats_sent;
	int results_seen;
	int mismatches;
	bit calm;
	bit hold_req;
	logic [8:0] chunk [$];

	// Character classes.
	function automatic bit dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha_us(logic [7:0] c);
		return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (dec(c))
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	function automatic logic [3:0] punct_token(logic [7:0] c);
		case (c)
			"{": return TK_LBRACE;
			"}": return TK_RBRACE;
			"[": return TK_LBRACKET;
			"]": return TK_RBRACKET;
			"(": return TK_LPAREN;
			")": return TK_RPAREN;
			":": return TK_PAIR_SEP;
			",": return TK_ITEM_SEP;
			default: return TK_END;
		endcase
	endfunction

	function automatic void put(logic [1:0] rk, logic [3:0] tk, logic [23:0] st,
			logic [23:0] ln, logic [7:0] cb, bit hx, bit ng, logic [63:0] mag, bit ov,
			logic [3:0] ec);
		result_t r;
		if (beat_nres >= 2)
			return;
		r = '{result_kind: rk, token_kind: tk, start_offset: st, lexeme_length: ln,
			content_byte: cb, number_is_hex: hx, number_negative: ng, hex_magnitude: mag,
			hex_overflow: ov, error_code: ec, last_of_item: 1'b0};
		beat_results[beat_nres] = r;
		beat_nres++;
	endfunction

	function automatic void halt_with(logic [3:0] ec);
		put(RK_ERROR, TK_END, lx_start, 0, 0, 0, 0, 0, 0, ec);
		lx_halted = 1;
	endfunction

	function automatic bit count_ok();
		if (lx_count >= NumTextMax) begin
			halt_with(EC_TOO_LONG);
			return 0;
		end
		lx_count++;
		return 1;
	endfunction

	function automatic void take_hex(int d);
		if (lx_hex[63:60] != 0)
			lx_hex_ovf = 1;
		lx_hex = {lx_hex[59:0], 4'(d)};
	endfunction

	function automatic void lex_idle(logic [7:0] c, bit e);
		logic [3:0] pk;
		lx_mode = MD_IDLE;
		lx_start = lx_pos;
		if (e) begin
			put(RK_TOKEN, TK_END, lx_pos, 0, 0, 0, 0, 0, 0, 0);
			lx_mode = MD_DONE;
			return;
		end
		if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a)
			return;
		if (c == "/") begin
			lx_mode = MD_SLASH;
			return;
		end
		if (c == "\"") begin
			lx_mode = MD_STR;
			return;
		end
		if (c == "@") begin
			lx_mode = MD_TAG0;
			return;
		end
		if (alpha_us(c)) begin
			lx_mode = MD_IDENT;
			return;
		end
		if (dec(c) || c == "-") begin
			lx_count = 0;
			lx_hex = 0;
			lx_hex_ovf = 0;
			lx_neg = (c == "-");
			void'(count_ok());
			lx_mode = lx_neg ? MD_MINUS : (c == "0" ? MD_ZERO : MD_INT);
			return;
		end
		pk = punct_token(c);
		if (pk != TK_END)
			put(RK_TOKEN, pk, lx_pos, 1, 0, 0, 0, 0, 0, 0);
		else
			halt_with(EC_UNKNOWN);
	endfunction

	function automatic void close_token(logic [3:0] kind, logic [7:0] c, bit e);
		logic [23:0] len;
		bit hx;
		len = lx_pos - lx_start;
		hx = (lx_mode == MD_HEX);
		if (kind == TK_NUM)
			put(RK_TOKEN, TK_NUM, lx_start, len, 0, hx, lx_neg, hx ? lx_hex : 64'd0,
				hx && lx_hex_ovf, 0);
		else
			put(RK_TOKEN, kind, lx_start, len, 0, 0, 0, 0, 0, 0);
		lex_idle(c, e);
	endfunction

	function automatic void number_section(logic [7:0] c, bit e, mode_t run, mode_t us,
			bit dot_ok, bit exp_ok);
		if (e)
			close_token(TK_NUM, c, e);
		else if (dec(c)) begin
			if (count_ok())
				lx_mode = run;
		end else if (c == "_")
			lx_mode = us;
		else if (dot_ok && c == ".") begin
			if (count_ok())
				lx_mode = MD_FRAC0;
		end else if (exp_ok && (c == "e" || c == "E")) begin
			if (count_ok())
				lx_mode = MD_EXP0;
		end else
			close_token(TK_NUM, c, e);
	endfunction

	function automatic void separator_run(logic [7:0] c, bit e, mode_t run);
		if (!e && c == "_")
			return;
		if (!e && dec(c)) begin
			if (count_ok())
				lx_mode = run;
			return;
		end
		halt_with(EC_SEPARATOR);
	endfunction

	function automatic int escape_value(logic [7:0] c);
		case (c)
			"r": return 8'h0d;
			"n": return 8'h0a;
			"t": return 8'h09;
			"0": return 0;
			"'": return 8'h27;
			"\\": return 8'h5c;
			"\"": return 8'h22;
			default: return -1;
		endcase
	endfunction

	function automatic void lex_byte(logic [7:0] c, bit e);
		int v;
		case (lx_mode)
			MD_SLASH: begin
				if (!e && c == "/")
					lx_mode = MD_COMMENT;
				else
					halt_with(EC_UNKNOWN);
			end
			MD_COMMENT: begin
				if (e)
					lex_idle(c, e);
				else if (c == 8'h0a)
					lx_mode = MD_IDLE;
			end
			MD_MINUS: begin
				if (!e && dec(c)) begin
					void'(count_ok());
					lx_mode = (c == "0") ? MD_ZERO : MD_INT;
				end else
					halt_with(EC_UNKNOWN);
			end
			MD_IDENT, MD_TAG: begin
				if (e || !(alpha_us(c) || dec(c)))
					close_token(lx_mode == MD_IDENT ? TK_IDENT : TK_TAG, c, e);
			end
			MD_TAG0: begin
				if (!e && alpha_us(c))
					lx_mode = MD_TAG;
				else
					halt_with(EC_UNKNOWN);
			end
			MD_STR: begin
				if (e)
					halt_with(EC_UNTERM);
				else if (c == "\"") begin
					put(RK_TOKEN, TK_STR, lx_start, lx_pos + 1 - lx_start, 0, 0, 0, 0, 0, 0);
					lx_mode = MD_IDLE;
				end else if (c == 8'h0a || c == 8'h0d || c == 8'h09)
					halt_with(EC_STR_CHAR);
				else if (c == "\\")
					lx_mode = MD_ESC;
				else
					put(RK_BYTE, TK_STR, lx_start, 0, c, 0, 0, 0, 0, 0);
			end
			MD_ESC: begin
				v = e ? -1 : escape_value(c);
				if (v < 0)
					halt_with(EC_ESCAPE);
				else begin
					put(RK_BYTE, TK_STR, lx_start, 0, 8'(v), 0, 0, 0, 0, 0);
					lx_mode = MD_STR;
				end
			end
			MD_ZERO: begin
				if (!e && (c == "x" || c == "X"))
					lx_mode = MD_HEX0;
				else
					number_section(c, e, MD_INT, MD_INT_US, 1, 1);
			end
			MD_INT: number_section(c, e, MD_INT, MD_INT_US, 1, 1);
			MD_FRAC: number_section(c, e, MD_FRAC, MD_FRAC_US, 0, 1);
			MD_EXP: number_section(c, e, MD_EXP, MD_EXP_US, 0, 0);
			MD_INT_US: separator_run(c, e, MD_INT);
			MD_FRAC_US: separator_run(c, e, MD_FRAC);
			MD_EXP_US: separator_run(c, e, MD_EXP);
			MD_FRAC0, MD_EXP_SIGN: begin
				if (!e && dec(c)) begin
					if (count_ok())
						lx_mode = (lx_mode == MD_FRAC0) ? MD_FRAC : MD_EXP;
				end else
					halt_with(EC_NO_DIGIT);
			end
			MD_EXP0: begin
				if (!e && dec(c)) begin
					if (count_ok())
						lx_mode = MD_EXP;
				end else if (!e && (c == "+" || c == "-")) begin
					if (count_ok())
						lx_mode = MD_EXP_SIGN;
				end else
					halt_with(EC_NO_DIGIT);
			end
			MD_HEX0: begin
				v = e ? -1 : hex_digit(c);
				if (v < 0)
					halt_with(EC_NO_HEX);
				else begin
					take_hex(v);
					lx_mode = MD_HEX;
				end
			end
			MD_HEX: begin
				v = e ? -1 : hex_digit(c);
				if (v >= 0)
					take_hex(v);
				else if (!e && c == "_")
					lx_mode = MD_HEX_US;
				else
					close_token(TK_NUM, c, e);
			end
			MD_HEX_US: begin
				if (!(!e && c == "_")) begin
					v = e ? -1 : hex_digit(c);
					if (v < 0)
						halt_with(EC_SEPARATOR);
					else begin
						take_hex(v);
						lx_mode = MD_HEX;
					end
				end
			end
			default: lex_idle(c, e);
		endcase
	endfunction

	// Predict the results of one accepted beat and queue them.
	function automatic void tokenize_beat(logic [7:0] c, bit eos);
		bit e;
		e = eos || c == 0;
		beat_nres = 0;
		if (lx_halted)
			return;
		if (lx_mode == MD_DONE)
			put(RK_TOKEN, TK_END, lx_pos, 0, 0, 0, 0, 0, 0, 0);
		else if (!e && lx_pos == 24'hFFFFFF)
			halt_with(EC_SRC_LONG);
		else begin
			lex_byte(c, e);
			if (!e && !lx_halted)
				lx_pos++;
		end
		if (beat_nres > 0)
			beat_results[beat_nres - 1].last_of_item = 1'b1;
		for (int i = 0; i < beat_nres; i++)
			pending_tokens.push_back(beat_results[i]);
	endfunction

	// Clock generator.
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 300000);
		$display("[config_text_tokenizer_core] ERROR");
		$finish;
	end

	// Receiver: random back-pressure bursts, one long hold on request.
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (80) @(posedge clk);
				hold_req = 0;
			end else if (calm || $urandom_range(0, 3) != 0) begin
				out_ready <= 1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				out_ready <= 0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Output monitor: each beat is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d token %0d",
					$time, result_kind, token_kind);
				mismatches++;
			end else begin
				w = pending_tokens.pop_front();
				check_field("result_kind", w.result_kind, result_kind);
				check_field("token_kind", w.token_kind, token_kind);
				check_field("start_offset", w.start_offset, start_offset);
				check_field("lexeme_length", w.lexeme_length, lexeme_length);
				check_field("content_byte", w.content_byte, content_byte);
				check_field("number_is_hex", w.number_is_hex, number_is_hex);
				check_field("number_negative", w.number_negative, number_negative);
				check_field("hex_magnitude", w.hex_magnitude, hex_magnitude);
				check_field("hex_overflow", w.hex_overflow, hex_overflow);
				check_field("error_code", w.error_code, error_code);
				check_field("last_of_item", w.last_of_item, last_of_item);
			end
		end
	end

	// Sender side: one beat, held until accepted, then predicted.
	task automatic send_beat(logic [7:0] b, bit eos);
		in_valid <= 1;
		source_byte <= b;
		end_of_source <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
		tokenize_beat(b, eos);
		if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			chunk.push_back({1'b0, s[i]});
	endtask

	task automatic push_ident();
		string a = "_abcxyzAQZ";
		string m = "_09azAZkq7";
		chunk.push_back({1'b0, a[$urandom_range(0, 9)]});
		repeat ($urandom_range(0, 6))
			chunk.push_back({1'b0, m[$urandom_range(0, 9)]});
	endtask

	task automatic push_digits(int n);
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 2)) chunk.push_back({1'b0, 8'h5f});
			chunk.push_back({1'b0, 8'(8'h30 + $urandom_range(0, 9))});
		end
	endtask

	// One random token, or whitespace or a comment, followed by a separator.
	task automatic push_random_token();
		string hx = "0123456789abcdefABCDEF";
		string esc = "rnt0'\\\"";
		string sep = " \t\r\n{}[]():,";
		int v;
		bit lead;
		case ($urandom_range(0, 9))
			0: push_ident();
			1: begin
				chunk.push_back({1'b0, 8'h40});
				push_ident();
			end
			2, 3: begin
				if ($urandom_range(0, 60) == 0) begin
					// Number text right at its length limit.
					push_text("-");
					repeat (NumTextMax - 1) chunk.push_back({1'b0, 8'h37});
				end else begin
					if ($urandom_range(0, 2) == 0)
						push_text("-");
					chunk.push_back({1'b0, 8'(8'h30 + $urandom_range(0, 9))});
					push_digits($urandom_range(0, 5));
					if ($urandom_range(0, 1)) begin
						push_text(".");
						chunk.push_back({1'b0, 8'h35});
						push_digits($urandom_range(0, 3));
					end
					if ($urandom_range(0, 1)) begin
						push_text($urandom_range(0, 1) ? "e" : "E");
						v = $urandom_range(0, 2);
						if (v == 1)
							push_text("+");
						else if (v == 2)
							push_text("-");
						chunk.push_back({1'b0, 8'h32});
						push_digits($urandom_range(0, 2));
					end
				end
			end
			4: begin
				if ($urandom_range(0, 2) == 0)
					push_text("-");
				push_text($urandom_range(0, 1) ? "0x" : "0X");
				// Separators only between digits, never right after the prefix.
				lead = 1;
				repeat ($urandom_range(1, 20)) begin
					if (!lead && $urandom_range(0, 6) == 0)
						repeat ($urandom_range(1, 2)) chunk.push_back({1'b0, 8'h5f});
					chunk.push_back({1'b0, hx[$urandom_range(0, 21)]});
					lead = 0;
				end
			end
			5, 6: begin
				push_text("\"");
				repeat ($urandom_range(0, 8)) begin
					v = $urandom_range(0, 9);
					if (v < 2) begin
						push_text("\\");
						chunk.push_back({1'b0, esc[$urandom_range(0, 6)]});
					end else if (v == 2)
						chunk.push_back({1'b0, 8'($urandom_range(128, 255))});
					else begin
						v = $urandom_range(32, 126);
						if (v == 8'h22 || v == 8'h5c)
							v = 8'h71;
						chunk.push_back({1'b0, 8'(v)});
					end
				end
				push_text("\"");
			end
			7: begin
				push_text("//");
				repeat ($urandom_range(0, 10)) begin
					v = $urandom_range(1, 255);
					chunk.push_back({1'b0, 8'(v == 10 ? 11 : v)});
				end
				push_text("\n");
			end
			default: ;
		endcase
		chunk.push_back({1'b0, sep[$urandom_range(0, 11)]});
	endtask

	// Closing sequence: a clean end or one of the errors, which halts the block.
	task automatic push_ending(int pick);
		case (pick)
			0: chunk.push_back(9'h100);
			1: chunk.push_back(9'h000);
			2: push_text("#");
			3: begin
				push_text("\"ab");
				chunk.push_back(9'h100);
			end
			4: push_text("\"a\n");
			5: push_text("\"\\q");
			6: push_text("12_ ");
			7: push_text("0x ");
			8: push_text("1. ");
			9: push_text("3e+x");
			10: repeat (NumTextMax + 1) chunk.push_back({1'b0, 8'h31});
			11: push_text("/x");
			12: push_text("-a");
			13: push_text("@1");
			default: begin
				chunk.push_back({1'b0, 8'h80});
			end
		endcase
		// Further beats after the end or the error.
		repeat (3) chunk.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
	endtask

	typedef struct {
		logic [7:0] b;
		bit chk;
		logic [3:0] tk;
		int off;
		int len;
	} stim_row_t;

	stim_row_t rows [31] = '{
		'{"{", 1, TK_LBRACE, 0, 1}, '{" ", 0, 0, 0, 0}, '{"a", 0, 0, 0, 0},
		'{"_", 0, 0, 0, 0}, '{",", 1, TK_IDENT, 2, 2}, '{"@", 0, 0, 0, 0},
		'{"t", 0, 0, 0, 0}, '{8'h09, 1, TK_TAG, 5, 2}, '{"-", 0, 0, 0, 0},
		'{"0", 0, 0, 0, 0}, '{"x", 0, 0, 0, 0}, '{"F", 0, 0, 0, 0},
		'{"_", 0, 0, 0, 0}, '{"f", 0, 0, 0, 0}, '{8'h0a, 1, TK_NUM, 8, 6},
		'{"\"", 0, 0, 0, 0}, '{8'hA9, 0, 0, 0, 0}, '{"\\", 0, 0, 0, 0},
		'{"n", 0, 0, 0, 0}, '{"\"", 1, TK_STR, 15, 5}, '{"9", 0, 0, 0, 0},
		'{".", 0, 0, 0, 0}, '{"5", 0, 0, 0, 0}, '{"e", 0, 0, 0, 0},
		'{"-", 0, 0, 0, 0}, '{"3", 0, 0, 0, 0}, '{"]", 1, TK_NUM, 20, 6},
		'{"/", 0, 0, 0, 0}, '{"/", 0, 0, 0, 0}, '{8'hFF, 0, 0, 0, 0},
		'{8'h0a, 0, 0, 0, 0}
	};

	// Main stimulus.
	initial begin
		int ending;
		bit held;
		bit paused;
		logic [8:0] item;
		arst_n = 0;
		in_valid = 0;
		source_byte = 0;
		end_of_source = 0;
		calm = 0;
		hold_req = 0;
		beats_sent = 0;
		results_seen = 0;
		mismatches = 0;
		lx_mode = MD_IDLE;
		lx_pos = 0;
		lx_start = 0;
		lx_count = 0;
		lx_hex = 0;
		lx_hex_ovf = 0;
		lx_neg = 0;
		lx_halted = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed table: token shapes with their offsets and lengths.
		foreach (rows[i]) begin
			send_beat(rows[i].b, 0);
			if (rows[i].chk && (beat_nres == 0 || beat_results[0].result_kind != RK_TOKEN ||
					beat_results[0].token_kind != rows[i].tk ||
					beat_results[0].start_offset != rows[i].off ||
					beat_results[0].lexeme_length != rows[i].len)) begin
				$display("%0t: row %0d, expected token %0d at %0d len %0d, predicted other",
					$time, i, rows[i].tk, rows[i].off, rows[i].len);
				mismatches++;
			end
		end

		// Random well-formed text.
		held = 0;
		paused = 0;
		while (beats_sent < RandomBeats) begin
			push_random_token();
			while (chunk.size() > 0) begin
				item = chunk.pop_front();
				if (!held && beats_sent >= 200) begin
					held = 1;
					hold_req = 1;
				end
				if (!paused && beats_sent >= 350) begin
					paused = 1;
					in_valid <= 0;
					do
						@(posedge clk);
					while (pending_tokens.size() != 0);
				end
				calm = beats_sent >= 470;
				send_beat(item[7:0], item[8]);
			end
		end

		ending = $urandom_range(0, 14);
		push_ending(ending);
		while (chunk.size() > 0) begin
			item = chunk.pop_front();
			send_beat(item[7:0], item[8]);
		end
		in_valid <= 0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d source beats, checked %0d results, closing case %0d (%s).",
			beats_sent, results_seen, ending, lx_halted ? "error halt" : "end of source");
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("[config_text_tokenizer_core] OK");
		else
			$display("[config_text_tokenizer_core] ERROR");
		$finish;
	end

endmodule
